[hdl/assert_macros.svh]
// Assertion macros used by the GLL parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/gll_pkg.sv]
// Constants and helper functions for the GLL sentence parser.
`timescale 1ns / 1ps
package gll_pkg;

  localparam int MAX_FRAC_DIGITS_DEF = 5;

  // Characters of interest
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [3:0] HDR_LEN   = 4'd6;
  localparam logic [3:0] FIELD_MAX = 4'd15;
  localparam logic [3:0] CIF_MAX   = 4'd15;

  localparam logic [3:0] FLD_HEADER = 4'd0;
  localparam logic [3:0] FLD_LAT    = 4'd1;
  localparam logic [3:0] FLD_LAT_HS = 4'd2;
  localparam logic [3:0] FLD_LON    = 4'd3;
  localparam logic [3:0] FLD_LON_HS = 4'd4;

  localparam logic [3:0] LAT_DEG_LEN = 4'd2;
  localparam logic [3:0] LON_DEG_LEN = 4'd3;

  localparam logic [6:0] MIN_INT_MAX = 7'd99;

  // Scale factors into 1e-7 degree units
  localparam int unsigned E7 = 10_000_000;
  localparam int unsigned E5 = 100_000;

  // Minutes numerator fits 30 bits for any fraction length; divide by 60 via reciprocal
  localparam int          NUM_W       = 30;
  localparam int          RECIP_SHIFT = 36;
  localparam int          RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP_60 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60);
  localparam int          PROD_W      = NUM_W + RECIP_W;
  localparam int          QUOT_W      = 25;

  localparam int LAT_W     = 31;
  localparam int LON_W     = 35;
  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      3'd7:    p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;  // $
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h47;  // G
      3'd4:    ch = 8'h4C;  // L
      3'd5:    ch = 8'h4C;  // L
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hdl/nmea_gll_position_parser.sv]
// GLL sentence parser: byte-wise field scanner and fixed-point position pipeline.
//
// Usage: feed received characters one per request on the in_ channel
// (in_valid/in_ready/in_rx_byte). A line ending in a newline whose first field
// is exactly $GPGLL yields one request on the out_ channel carrying signed
// latitude and longitude in 1e-7 degree units; other lines yield nothing.
// Throughput: one byte per cycle while in_ready is high. Each byte updates the
// scanner state in the cycle it is taken; a newline hands its snapshot to a
// four-register result pipeline (snapshot, constant scaling, reciprocal
// multiply for the /60, sum and sign) whose last register drives out_valid.
// The pipeline stages collapse bubbles independently: while out_ready is low
// bytes are still taken until all four stages hold results, and only then does
// in_ready drop. The reciprocal multiply is the deepest path.
// Reset (rst_n low, synchronous) clears the scanner to the start of a line and
// empties the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nmea_gll_position_parser
  import gll_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [LAT_W-1:0] out_latitude_e7,
  output logic signed [LON_W-1:0] out_longitude_e7
);

  localparam int          FRAC_W      = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam logic [2:0]  FD          = 3'(MAX_FRAC_DIGITS);
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(10 ** MAX_FRAC_DIGITS - 1);
  localparam int unsigned FRAC_TO_E7  = 10 ** (7 - MAX_FRAC_DIGITS);

  // Scanner state
  logic                 hdr_ok_r, hdr_ok_nxt;
  logic                 hdr_done_r, hdr_done_nxt;
  logic [3:0]           field_r, field_nxt;
  logic [3:0]           cif_r, cif_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 infrac_r, infrac_nxt;
  logic [2:0]           seen_r, seen_nxt;
  logic                 dir_r, dir_nxt;
  logic [1:0]           neg_r, neg_nxt;
  logic [LAT_DEG_W-1:0] lat_deg_r, lat_deg_nxt;
  logic [6:0]           lat_hund_r, lat_hund_nxt;
  logic [6:0]           lat_mint_r, lat_mint_nxt;
  logic [FRAC_W-1:0]    lat_mfrac_r, lat_mfrac_nxt;
  logic [LON_DEG_W-1:0] lon_deg_r, lon_deg_nxt;
  logic [6:0]           lon_hund_r, lon_hund_nxt;
  logic [6:0]           lon_mint_r, lon_mint_nxt;
  logic [FRAC_W-1:0]    lon_mfrac_r, lon_mfrac_nxt;

  // Shared coordinate datapath
  logic                 is_lon;
  logic [3:0]           deg_len;
  logic                 at_min_start;
  logic                 in_deg;
  logic                 stop_e, frac_e;
  logic [2:0]           seen_e;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [LON_DEG_W-1:0] cur_deg, new_deg;
  logic [6:0]           cur_hund, new_hund, hund_inc;
  logic [6:0]           cur_mint, new_mint;
  logic [FRAC_W-1:0]    cur_mfrac, new_mfrac, frac_inc;
  logic [9:0]           min_ip;

  logic in_fire;
  logic emit;

  // Result pipeline
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, out_valid_r;

  logic [LAT_DEG_W-1:0] s1_lat_deg_r;
  logic [6:0]           s1_lat_hund_r, s1_lat_mint_r;
  logic [FRAC_W-1:0]    s1_lat_mfrac_r;
  logic [LON_DEG_W-1:0] s1_lon_deg_r;
  logic [6:0]           s1_lon_hund_r, s1_lon_mint_r;
  logic [FRAC_W-1:0]    s1_lon_mfrac_r;
  logic [1:0]           s1_neg_r;

  logic [NUM_W-1:0]     s2_lat_num_r, s2_lon_num_r;
  logic [NUM_W-1:0]     s2_lat_base_r;
  logic [LON_W-2:0]     s2_lon_base_r;
  logic [1:0]           s2_neg_r;

  logic [PROD_W-1:0]    lat_prod, lon_prod;
  logic [QUOT_W-1:0]    s3_lat_q_r, s3_lon_q_r;
  logic [NUM_W-1:0]     s3_lat_base_r;
  logic [LON_W-2:0]     s3_lon_base_r;
  logic [1:0]           s3_neg_r;

  logic [LAT_W-1:0]     lat_sum;
  logic [LON_W-1:0]     lon_sum;
  logic signed [LAT_W-1:0] lat_out_r;
  logic signed [LON_W-1:0] lon_out_r;

  assign rdy4 = !out_valid_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ready = rdy1;
  assign in_fire  = in_valid && in_ready;
  assign emit     = in_fire && (in_rx_byte == CH_NL) && hdr_ok_r && hdr_done_r;

  // Select the coordinate being read (field 1 or 3)
  always_comb begin
    is_lon       = (field_r == FLD_LON);
    deg_len      = is_lon ? LON_DEG_LEN : LAT_DEG_LEN;
    at_min_start = (cif_r == deg_len);
    in_deg       = (cif_r < deg_len);
    stop_e       = at_min_start ? 1'b0 : stopped_r;
    frac_e       = at_min_start ? 1'b0 : infrac_r;
    seen_e       = at_min_start ? 3'd0 : seen_r;
    is_digit     = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
    digit        = 4'(in_rx_byte - CH_ZERO);
    cur_deg      = is_lon ? lon_deg_r : LON_DEG_W'(lat_deg_r);
    cur_hund     = is_lon ? lon_hund_r : lat_hund_r;
    cur_mint     = is_lon ? lon_mint_r : lat_mint_r;
    cur_mfrac    = is_lon ? lon_mfrac_r : lat_mfrac_r;
    hund_inc     = (seen_e == 3'd0) ? 7'(7'(digit) * 7'd10) : 7'(digit);
    min_ip       = 10'(10'(cur_mint) * 10'd10) + 10'(digit);
    frac_inc     = FRAC_W'(28'(digit) * 28'(pow10(FD - 3'd1 - seen_e)));
  end

  always_comb begin
    hdr_ok_nxt    = hdr_ok_r;
    hdr_done_nxt  = hdr_done_r;
    field_nxt     = field_r;
    cif_nxt       = cif_r;
    stopped_nxt   = stopped_r;
    infrac_nxt    = infrac_r;
    seen_nxt      = seen_r;
    dir_nxt       = dir_r;
    neg_nxt       = neg_r;
    lat_deg_nxt   = lat_deg_r;
    lat_hund_nxt  = lat_hund_r;
    lat_mint_nxt  = lat_mint_r;
    lat_mfrac_nxt = lat_mfrac_r;
    lon_deg_nxt   = lon_deg_r;
    lon_hund_nxt  = lon_hund_r;
    lon_mint_nxt  = lon_mint_r;
    lon_mfrac_nxt = lon_mfrac_r;
    new_deg       = cur_deg;
    new_hund      = cur_hund;
    new_mint      = cur_mint;
    new_mfrac     = cur_mfrac;

    if (in_fire) begin
      if (in_rx_byte == CH_NL) begin
        hdr_ok_nxt    = 1'b1;
        hdr_done_nxt  = 1'b0;
        field_nxt     = '0;
        cif_nxt       = '0;
        stopped_nxt   = 1'b0;
        infrac_nxt    = 1'b0;
        seen_nxt      = '0;
        dir_nxt       = 1'b0;
        neg_nxt       = '0;
        lat_deg_nxt   = '0;
        lat_hund_nxt  = '0;
        lat_mint_nxt  = '0;
        lat_mfrac_nxt = '0;
        lon_deg_nxt   = '0;
        lon_hund_nxt  = '0;
        lon_mint_nxt  = '0;
        lon_mfrac_nxt = '0;
      end else if (in_rx_byte == CH_COMMA) begin
        if (field_r == FLD_HEADER) begin
          if (hdr_ok_r && (cif_r == HDR_LEN)) hdr_done_nxt = 1'b1;
          else hdr_ok_nxt = 1'b0;
        end else if ((field_r == FLD_LAT_HS) || (field_r == FLD_LON_HS)) begin
          // hemisphere counts only as a lone S or W
          if ((cif_r == 4'd1) && dir_r) begin
            if (field_r == FLD_LAT_HS) neg_nxt[0] = 1'b1;
            else neg_nxt[1] = 1'b1;
          end
        end
        if (field_r != FIELD_MAX) field_nxt = field_r + 4'd1;
        cif_nxt     = '0;
        stopped_nxt = 1'b0;
        infrac_nxt  = 1'b0;
        seen_nxt    = '0;
        dir_nxt     = 1'b0;
      end else begin
        case (field_r)
          FLD_HEADER: begin
            if (!((cif_r < HDR_LEN) && (in_rx_byte == header_char(cif_r[2:0]))))
              hdr_ok_nxt = 1'b0;
          end
          FLD_LAT, FLD_LON: begin
            stopped_nxt = stop_e;
            infrac_nxt  = frac_e;
            seen_nxt    = seen_e;
            if (!stop_e) begin
              if (is_digit) begin
                if (in_deg) begin
                  if (!frac_e) begin
                    new_deg = LON_DEG_W'(11'(11'(cur_deg) * 11'd10) + 11'(digit));
                  end else if (seen_e < 3'd2) begin
                    new_hund = cur_hund + hund_inc;
                    seen_nxt = seen_e + 3'd1;
                  end
                end else if (!frac_e) begin
                  if (min_ip > 10'(MIN_INT_MAX)) begin
                    // minutes saturate and the rest of the number is ignored
                    new_mint    = MIN_INT_MAX;
                    new_mfrac   = FRAC_MAX;
                    stopped_nxt = 1'b1;
                  end else begin
                    new_mint = min_ip[6:0];
                  end
                end else if (seen_e < FD) begin
                  new_mfrac = cur_mfrac + frac_inc;
                  seen_nxt  = seen_e + 3'd1;
                end
              end else if ((in_rx_byte == CH_POINT) && !frac_e) begin
                infrac_nxt = 1'b1;
              end else begin
                stopped_nxt = 1'b1;
              end
            end
            if (is_lon) begin
              lon_deg_nxt   = new_deg;
              lon_hund_nxt  = new_hund;
              lon_mint_nxt  = new_mint;
              lon_mfrac_nxt = new_mfrac;
            end else begin
              lat_deg_nxt   = new_deg[LAT_DEG_W-1:0];
              lat_hund_nxt  = new_hund;
              lat_mint_nxt  = new_mint;
              lat_mfrac_nxt = new_mfrac;
            end
          end
          FLD_LAT_HS, FLD_LON_HS: begin
            if (cif_r == 4'd0)
              dir_nxt = (in_rx_byte == CH_S) || (in_rx_byte == CH_W);
          end
          default: begin
          end
        endcase
        if (cif_r != CIF_MAX) cif_nxt = cif_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_ok_r    <= 1'b1;
      hdr_done_r  <= 1'b0;
      field_r     <= '0;
      cif_r       <= '0;
      stopped_r   <= 1'b0;
      infrac_r    <= 1'b0;
      seen_r      <= '0;
      dir_r       <= 1'b0;
      neg_r       <= '0;
      lat_deg_r   <= '0;
      lat_hund_r  <= '0;
      lat_mint_r  <= '0;
      lat_mfrac_r <= '0;
      lon_deg_r   <= '0;
      lon_hund_r  <= '0;
      lon_mint_r  <= '0;
      lon_mfrac_r <= '0;
    end else begin
      hdr_ok_r    <= hdr_ok_nxt;
      hdr_done_r  <= hdr_done_nxt;
      field_r     <= field_nxt;
      cif_r       <= cif_nxt;
      stopped_r   <= stopped_nxt;
      infrac_r    <= infrac_nxt;
      seen_r      <= seen_nxt;
      dir_r       <= dir_nxt;
      neg_r       <= neg_nxt;
      lat_deg_r   <= lat_deg_nxt;
      lat_hund_r  <= lat_hund_nxt;
      lat_mint_r  <= lat_mint_nxt;
      lat_mfrac_r <= lat_mfrac_nxt;
      lon_deg_r   <= lon_deg_nxt;
      lon_hund_r  <= lon_hund_nxt;
      lon_mint_r  <= lon_mint_nxt;
      lon_mfrac_r <= lon_mfrac_nxt;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= emit;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // Stage 1: snapshot of the finished sentence
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_lat_deg_r   <= lat_deg_r;
      s1_lat_hund_r  <= lat_hund_r;
      s1_lat_mint_r  <= lat_mint_r;
      s1_lat_mfrac_r <= lat_mfrac_r;
      s1_lon_deg_r   <= lon_deg_r;
      s1_lon_hund_r  <= lon_hund_r;
      s1_lon_mint_r  <= lon_mint_r;
      s1_lon_mfrac_r <= lon_mfrac_r;
      s1_neg_r       <= neg_r;
    end
  end

  // Stage 2: minutes*10^(7-F) numerator and degree part (whole and hundredths), constant scaling
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_lat_num_r  <= NUM_W'(NUM_W'(s1_lat_mint_r) * NUM_W'(E7))
                     + NUM_W'(NUM_W'(s1_lat_mfrac_r) * NUM_W'(FRAC_TO_E7));
      s2_lon_num_r  <= NUM_W'(NUM_W'(s1_lon_mint_r) * NUM_W'(E7))
                     + NUM_W'(NUM_W'(s1_lon_mfrac_r) * NUM_W'(FRAC_TO_E7));
      s2_lat_base_r <= NUM_W'(NUM_W'(s1_lat_deg_r) * NUM_W'(E7))
                     + NUM_W'(NUM_W'(s1_lat_hund_r) * NUM_W'(E5));
      s2_lon_base_r <= (LON_W-1)'((LON_W-1)'(s1_lon_deg_r) * (LON_W-1)'(E7))
                     + (LON_W-1)'((LON_W-1)'(s1_lon_hund_r) * (LON_W-1)'(E5));
      s2_neg_r      <= s1_neg_r;
    end
  end

  // Stage 3: floor(num / 60) by reciprocal multiply, exact for num < 2^30
  assign lat_prod = PROD_W'(s2_lat_num_r) * PROD_W'(RECIP_60);
  assign lon_prod = PROD_W'(s2_lon_num_r) * PROD_W'(RECIP_60);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_lat_q_r    <= lat_prod[RECIP_SHIFT +: QUOT_W];
      s3_lon_q_r    <= lon_prod[RECIP_SHIFT +: QUOT_W];
      s3_lat_base_r <= s2_lat_base_r;
      s3_lon_base_r <= s2_lon_base_r;
      s3_neg_r      <= s2_neg_r;
    end
  end

  // Stage 4: sum and hemisphere sign into the output register
  assign lat_sum = LAT_W'(s3_lat_base_r) + LAT_W'(s3_lat_q_r);
  assign lon_sum = LON_W'(s3_lon_base_r) + LON_W'(s3_lon_q_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      lat_out_r <= s3_neg_r[0] ? -$signed(lat_sum) : $signed(lat_sum);
      lon_out_r <= s3_neg_r[1] ? -$signed(lon_sum) : $signed(lon_sum);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_latitude_e7  = lat_out_r;
  assign out_longitude_e7 = lon_out_r;

  // Input only stalls once every result stage is occupied and blocked
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !in_ready,
    v1_r && v2_r && v3_r && out_valid_r && !out_ready)
  // A newline always returns the scanner to the start of a line
  `ASSERT_NEXT(a_newline_clears, clk, rst_n, in_fire && (in_rx_byte == CH_NL),
    (field_r == FLD_HEADER) && (cif_r == 4'd0) && hdr_ok_r && !hdr_done_r && (neg_r == 2'b00))
  // Header completion is only reached with a matching header and leaves field 0
  `ASSERT_IMPLIES(a_header_done_ok, clk, rst_n, hdr_done_r,
    hdr_ok_r && (field_r != FLD_HEADER))

endmodule
